### hdl/scpt_pkg.sv
package scpt_pkg;

  localparam int COUNT_BITS    = 32;
  localparam int TABLE_ENTRIES = 257;
  localparam int ADDR_BITS     = $clog2(TABLE_ENTRIES);
  localparam int VALUE_BITS    = 32;
  localparam int SYMBOL_BITS   = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_BITS-1:0]  LAST_ENTRY    = ADDR_BITS'(TABLE_ENTRIES - 1);
  localparam logic [ADDR_BITS-1:0]  SENTINEL_BIN  = ADDR_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE     = COUNT_BITS'(1);

  typedef enum logic [1:0] {
    REQ_COUNT    = 2'd0,
    REQ_FINALIZE = 2'd1,
    REQ_READ     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    req_t                 req;
    logic [ADDR_BITS-1:0] addr;
    logic                 in_range;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CNT  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_FIN  = 4'b1000
  } back_state_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

endpackage

### hdl/scpt_ram.sv
module scpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/scpt_front.sv
module scpt_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type,
  input  logic [scpt_pkg::SYMBOL_BITS-1:0]      symbol,
  input  logic [scpt_pkg::ADDR_BITS-1:0]        entry_index,
  output scpt_pkg::queue_head_t                 head,
  input  logic                                  pop
);

  scpt_pkg::cmd_t                      queue [scpt_pkg::QUEUE_DEPTH];
  logic [scpt_pkg::QPTR_BITS-1:0]      wr_ptr;
  logic [scpt_pkg::QPTR_BITS-1:0]      rd_ptr;
  logic [scpt_pkg::QCNT_BITS-1:0]      fill;
  scpt_pkg::cmd_t                      cmd_in;
  logic                                push;
  logic                                do_pop;

  // Classify: count goes to bin symbol+1, read carries its index and range check
  always_comb begin
    cmd_in.req      = scpt_pkg::req_t'(req_type);
    cmd_in.in_range = 1'b1;
    case (scpt_pkg::req_t'(req_type))
      scpt_pkg::REQ_COUNT: begin
        cmd_in.addr = scpt_pkg::ADDR_BITS'({1'b0, symbol}) + scpt_pkg::ADDR_BITS'(1);
      end
      scpt_pkg::REQ_READ: begin
        cmd_in.addr     = entry_index;
        cmd_in.in_range = (entry_index <= scpt_pkg::LAST_ENTRY);
      end
      default: begin
        cmd_in.addr = '0;
      end
    endcase
  end

  assign busy       = (fill == scpt_pkg::QCNT_BITS'(scpt_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign do_pop     = pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.cmd   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + scpt_pkg::QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + scpt_pkg::QPTR_BITS'(1);
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + scpt_pkg::QCNT_BITS'(1);
        2'b01:   fill <= fill - scpt_pkg::QCNT_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/scpt_back.sv
module scpt_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  scpt_pkg::queue_head_t                 head,
  output logic                                  pop,
  output logic                                  done,
  output logic [scpt_pkg::VALUE_BITS-1:0]       entry_value,
  output logic                                  is_final
);

  scpt_pkg::back_state_t                   state;
  scpt_pkg::back_state_t                   state_next;
  logic [scpt_pkg::ADDR_BITS-1:0]          cur_addr;
  logic [scpt_pkg::ADDR_BITS-1:0]          cur_addr_next;
  logic [scpt_pkg::COUNT_BITS-1:0]         acc;
  logic [scpt_pkg::COUNT_BITS-1:0]         acc_next;
  logic                                    finalized;
  logic                                    finalized_next;
  logic [scpt_pkg::TABLE_ENTRIES-1:0]      entry_valid;
  logic                                    clear_all;
  logic                                    rd_live;
  logic                                    done_next;
  logic [scpt_pkg::VALUE_BITS-1:0]         value_next;

  logic                                    ram_we;
  logic [scpt_pkg::ADDR_BITS-1:0]          ram_waddr;
  logic [scpt_pkg::COUNT_BITS-1:0]         ram_wdata;
  logic                                    ram_re;
  logic [scpt_pkg::ADDR_BITS-1:0]          ram_raddr;
  logic [scpt_pkg::COUNT_BITS-1:0]         ram_q;
  logic [scpt_pkg::COUNT_BITS-1:0]         rd_val;
  logic [scpt_pkg::COUNT_BITS-1:0]         fin_sum;

  scpt_ram #(
    .WIDTH(scpt_pkg::COUNT_BITS),
    .DEPTH(scpt_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // An entry never written since the last clear reads as zero
  assign rd_val  = rd_live ? ram_q : '0;
  assign fin_sum = scpt_pkg::sat_add(rd_val, acc);

  always_comb begin
    state_next     = state;
    cur_addr_next  = cur_addr;
    acc_next       = acc;
    finalized_next = finalized;
    clear_all      = 1'b0;
    pop            = 1'b0;
    done_next      = 1'b0;
    value_next     = '0;
    ram_we         = 1'b0;
    ram_waddr      = cur_addr;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = cur_addr;

    case (state)
      scpt_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.req)
            scpt_pkg::REQ_COUNT: begin
              if (!finalized) begin
                ram_re        = 1'b1;
                ram_raddr     = head.cmd.addr;
                cur_addr_next = head.cmd.addr;
                state_next    = scpt_pkg::ST_CNT;
              end
            end
            scpt_pkg::REQ_READ: begin
              if (head.cmd.in_range) begin
                ram_re     = 1'b1;
                ram_raddr  = head.cmd.addr;
                state_next = scpt_pkg::ST_RD;
              end else begin
                done_next = 1'b1;
              end
            end
            scpt_pkg::REQ_FINALIZE: begin
              if (!finalized) begin
                // Seed the sentinel bin, then start the walk at the next entry
                ram_we        = 1'b1;
                ram_waddr     = scpt_pkg::SENTINEL_BIN;
                ram_wdata     = scpt_pkg::COUNT_ONE;
                acc_next      = scpt_pkg::COUNT_ONE;
                ram_re        = 1'b1;
                ram_raddr     = scpt_pkg::SENTINEL_BIN + scpt_pkg::ADDR_BITS'(1);
                cur_addr_next = scpt_pkg::SENTINEL_BIN + scpt_pkg::ADDR_BITS'(1);
                state_next    = scpt_pkg::ST_FIN;
              end
            end
            scpt_pkg::REQ_CLEAR: begin
              clear_all      = 1'b1;
              finalized_next = 1'b0;
            end
            default: begin
              state_next = scpt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      scpt_pkg::ST_CNT: begin
        ram_we     = 1'b1;
        ram_wdata  = scpt_pkg::sat_add(rd_val, scpt_pkg::COUNT_ONE);
        state_next = scpt_pkg::ST_IDLE;
      end
      scpt_pkg::ST_RD: begin
        done_next  = 1'b1;
        value_next = scpt_pkg::VALUE_BITS'(rd_val);
        state_next = scpt_pkg::ST_IDLE;
      end
      scpt_pkg::ST_FIN: begin
        // Write the running sum of this entry while fetching the next one
        ram_we    = 1'b1;
        ram_wdata = fin_sum;
        acc_next  = fin_sum;
        if (cur_addr == scpt_pkg::LAST_ENTRY) begin
          finalized_next = 1'b1;
          state_next     = scpt_pkg::ST_IDLE;
        end else begin
          ram_re        = 1'b1;
          ram_raddr     = cur_addr + scpt_pkg::ADDR_BITS'(1);
          cur_addr_next = cur_addr + scpt_pkg::ADDR_BITS'(1);
        end
      end
      default: begin
        state_next = scpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= scpt_pkg::ST_IDLE;
      finalized   <= 1'b0;
      entry_valid <= '0;
      done        <= 1'b0;
    end else begin
      state     <= state_next;
      finalized <= finalized_next;
      done      <= done_next;
      if (clear_all) begin
        entry_valid <= '0;
      end else if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_addr <= cur_addr_next;
    acc      <= acc_next;
    if (ram_re) begin
      rd_live <= entry_valid[ram_raddr];
    end
    if (done_next) begin
      entry_value <= value_next;
      is_final    <= finalized;
    end
  end

endmodule

### hdl/symbol_count_prefix_table_core.sv
// Symbol count / prefix table core: builds the FM-index C array of a byte text.
// A request is taken when start is high and busy is low; requests enter a
// two-deep queue, so busy rises only when that queue is full. The table lives
// in a 257-entry memory with one write and one registered read port. A count
// or in-range read passes through the execution unit as a memory read, then
// the write-back or the result. A clear, an ignored request or a read with an
// index above 256 is handled in the idle state alone. A finalize walks entries
// 1 to 256 once, one entry per cycle, writing each running sum while reading
// the next entry. A read result shows on entry_value and is_final for exactly
// one cycle with done high: for an index above 256 in the cycle after the
// request leaves the queue, else after the memory read and the ST_RD state; it
// cannot be held off, so capture it in that cycle. Reset and clear take effect
// at once through per-entry valid bits: there is no clearing pass.
module symbol_count_prefix_table_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         req_type,
  input  logic [scpt_pkg::SYMBOL_BITS-1:0]   symbol,
  input  logic [scpt_pkg::ADDR_BITS-1:0]     entry_index,
  output logic                               done,
  output logic [scpt_pkg::VALUE_BITS-1:0]    entry_value,
  output logic                               is_final
);

  scpt_pkg::queue_head_t head;
  logic                  pop;

  scpt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .symbol      (symbol),
    .entry_index (entry_index),
    .head        (head),
    .pop         (pop)
  );

  scpt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .done        (done),
    .entry_value (entry_value),
    .is_final    (is_final)
  );

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    scpt_pkg::req_t                   req;
    logic [scpt_pkg::SYMBOL_BITS-1:0] sym;
    logic [scpt_pkg::ADDR_BITS-1:0]   idx;
  } table_req_t;

  typedef struct packed {
    logic [scpt_pkg::VALUE_BITS-1:0] value;
    logic                            is_final_exp;
  } readback_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [1:0]                       req_type = scpt_pkg::REQ_COUNT;
  logic [scpt_pkg::SYMBOL_BITS-1:0] symbol = '0;
  logic [scpt_pkg::ADDR_BITS-1:0]   entry_index = '0;
  logic                             done;
  logic [scpt_pkg::VALUE_BITS-1:0]  entry_value;
  logic                             is_final;

  table_req_t req_fifo[$];
  readback_t  readback_q[$];

  // Shadow of the table and its mode
  logic [scpt_pkg::COUNT_BITS-1:0] bin_model[scpt_pkg::TABLE_ENTRIES];
  logic                            sums_ready = 1'b0;

  int n_sent = 0;
  int n_taken = 0;
  int err_count = 0;
  int n_items = 0;
  int cycle_cnt = 0;
  int burst_left = 1;
  int gap_left = 0;
  table_req_t drv_item;

  symbol_count_prefix_table_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .symbol      (symbol),
    .entry_index (entry_index),
    .done        (done),
    .entry_value (entry_value),
    .is_final    (is_final)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [scpt_pkg::COUNT_BITS-1:0] add_clamped(
      input logic [scpt_pkg::COUNT_BITS-1:0] a,
      input logic [scpt_pkg::COUNT_BITS-1:0] b);
    logic [scpt_pkg::COUNT_BITS:0] total;
    total = {1'b0, a} + {1'b0, b};
    if (total[scpt_pkg::COUNT_BITS]) return {scpt_pkg::COUNT_BITS{1'b1}};
    return total[scpt_pkg::COUNT_BITS-1:0];
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < scpt_pkg::TABLE_ENTRIES; i++) bin_model[i] = '0;
    sums_ready = 1'b0;
  endfunction

  // Update the shadow table for one accepted transaction; queue a readback for reads
  function automatic void apply_table_req(input logic [1:0] rq,
                                          input logic [scpt_pkg::SYMBOL_BITS-1:0] sym,
                                          input logic [scpt_pkg::ADDR_BITS-1:0] idx);
    readback_t rb;
    case (scpt_pkg::req_t'(rq))
      scpt_pkg::REQ_COUNT: begin
        if (!sums_ready)
          bin_model[sym + 1] = add_clamped(bin_model[sym + 1],
                                           scpt_pkg::COUNT_BITS'(1));
      end
      scpt_pkg::REQ_FINALIZE: begin
        if (!sums_ready) begin
          // entry 1 stands for the sentinel, so zero bytes drop out
          bin_model[1] = scpt_pkg::COUNT_BITS'(1);
          for (int i = 1; i < scpt_pkg::TABLE_ENTRIES; i++)
            bin_model[i] = add_clamped(bin_model[i], bin_model[i-1]);
          sums_ready = 1'b1;
        end
      end
      scpt_pkg::REQ_READ: begin
        rb.value        = (idx < scpt_pkg::TABLE_ENTRIES) ?
                          scpt_pkg::VALUE_BITS'(bin_model[idx]) : '0;
        rb.is_final_exp = sums_ready;
        readback_q.push_back(rb);
      end
      default: clear_model();
    endcase
  endfunction

  task automatic push_req(input scpt_pkg::req_t rq, input int sym, input int idx,
                          input bit live = 1'b1);
    table_req_t it;
    it.req = rq;
    it.sym = scpt_pkg::SYMBOL_BITS'(sym);
    it.idx = scpt_pkg::ADDR_BITS'(idx);
    req_fifo.push_back(it);
    if (live) n_items++;
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && n_sent != n_taken) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      start       <= 1'b0;
      req_type    <= 2'($urandom);
      symbol      <= scpt_pkg::SYMBOL_BITS'($urandom);
      entry_index <= scpt_pkg::ADDR_BITS'($urandom);
      gap_left    <= gap_left - 1;
    end else if (req_fifo.size() > 0) begin
      drv_item = req_fifo.pop_front();
      start       <= 1'b1;
      req_type    <= drv_item.req;
      symbol      <= drv_item.sym;
      entry_index <= drv_item.idx;
      n_sent      <= n_sent + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0, 1, 2: gap_left <= 0;
          3:       gap_left <= $urandom_range(20, 60);
          default: gap_left <= $urandom_range(1, 6);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results first, then record the transaction taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (readback_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual entry_value %0h is_final %0b",
                   $time, entry_value, is_final);
          err_count++;
        end else begin
          readback_t exp_rb;
          exp_rb = readback_q.pop_front();
          if (entry_value !== exp_rb.value) begin
            $display("%0t: entry_value mismatch: expected %0h actual %0h",
                     $time, exp_rb.value, entry_value);
            err_count++;
          end
          if (is_final !== exp_rb.is_final_exp) begin
            $display("%0t: is_final mismatch: expected %0b actual %0b",
                     $time, exp_rb.is_final_exp, is_final);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        n_taken <= n_taken + 1;
        apply_table_req(req_type, symbol, entry_index);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int txt_len;
    int base;
    int sym;
    int n_rd;
    bit wide_alpha;
    clear_model();

    // Directed: empty table, extremes, finalize, ignored requests, clear
    push_req(scpt_pkg::REQ_READ, 8'h00, 0);
    push_req(scpt_pkg::REQ_READ, 8'hFF, 256);
    push_req(scpt_pkg::REQ_READ, 8'h5A, 257);
    push_req(scpt_pkg::REQ_READ, 8'hA5, 511);
    push_req(scpt_pkg::REQ_COUNT, 8'h00, 0);
    push_req(scpt_pkg::REQ_COUNT, 8'hFF, 511);
    push_req(scpt_pkg::REQ_COUNT, 8'hFF, 0);
    push_req(scpt_pkg::REQ_COUNT, 8'hAA, 170);
    push_req(scpt_pkg::REQ_COUNT, 8'h55, 85);
    push_req(scpt_pkg::REQ_READ, 8'h00, 1);
    push_req(scpt_pkg::REQ_READ, 8'h00, 256);
    push_req(scpt_pkg::REQ_FINALIZE, 8'h00, 0);
    push_req(scpt_pkg::REQ_READ, 8'h00, 1);
    push_req(scpt_pkg::REQ_READ, 8'h00, 2);
    push_req(scpt_pkg::REQ_READ, 8'h00, 256);
    push_req(scpt_pkg::REQ_COUNT, 8'h07, 0, 1'b0);
    push_req(scpt_pkg::REQ_FINALIZE, 8'hFF, 511);
    push_req(scpt_pkg::REQ_READ, 8'h00, 8);
    push_req(scpt_pkg::REQ_READ, 8'h00, 0);
    push_req(scpt_pkg::REQ_READ, 8'h00, 300);
    push_req(scpt_pkg::REQ_CLEAR, 8'h00, 0);
    push_req(scpt_pkg::REQ_READ, 8'h00, 256);
    push_req(scpt_pkg::REQ_FINALIZE, 8'h00, 0);
    push_req(scpt_pkg::REQ_READ, 8'h00, 256);
    push_req(scpt_pkg::REQ_CLEAR, 8'hFF, 511);

    // Random: mostly whole texts (clear, counts, finalize, reads), some noise
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        push_req(scpt_pkg::REQ_CLEAR, $urandom, $urandom);
        txt_len    = $urandom_range(1, 40);
        wide_alpha = $urandom_range(0, 1);
        base       = $urandom_range(0, 252);
        for (int i = 0; i < txt_len; i++) begin
          sym = wide_alpha ? $urandom_range(0, 255) : base + $urandom_range(0, 3);
          push_req(scpt_pkg::REQ_COUNT, sym, $urandom);
          if ($urandom_range(0, 7) == 0)
            push_req(scpt_pkg::REQ_READ, $urandom, $urandom_range(0, 256));
        end
        if ($urandom_range(0, 9) != 0) begin
          push_req(scpt_pkg::REQ_FINALIZE, $urandom, $urandom);
          n_rd = $urandom_range(2, 8);
          for (int i = 0; i < n_rd; i++) begin
            case ($urandom_range(0, 7))
              0:       push_req(scpt_pkg::REQ_READ, $urandom, $urandom_range(257, 511));
              1:       push_req(scpt_pkg::REQ_READ, $urandom, 256);
              2:       push_req(scpt_pkg::REQ_READ, $urandom, base + $urandom_range(0, 4));
              default: push_req(scpt_pkg::REQ_READ, $urandom, $urandom_range(0, 256));
            endcase
          end
          if ($urandom_range(0, 3) == 0) begin
            push_req(scpt_pkg::REQ_COUNT, $urandom, $urandom, 1'b0);
            push_req(scpt_pkg::REQ_FINALIZE, $urandom, $urandom, 1'b0);
            push_req(scpt_pkg::REQ_READ, $urandom, $urandom_range(0, 256));
          end
        end
      end else begin
        txt_len = $urandom_range(5, 20);
        for (int i = 0; i < txt_len; i++)
          push_req(scpt_pkg::req_t'($urandom_range(0, 3)), $urandom, $urandom);
      end
    end

    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (req_fifo.size() == 0 && n_taken == n_sent);
    wait (readback_q.size() == 0);
    // let a trailing finalize walk finish and catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
